// File: rtl/core/tcgr_pkg.sv
// Shared constants, codes and word types for the text console glyph renderer.
package tcgr_pkg;

    // Glyph and screen geometry, in pixels.
    localparam int GLYPH_WIDTH   = 8;
    localparam int GLYPH_HEIGHT  = 8;
    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;

    // Font store.
    localparam int STORE_DEPTH = 2048;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Field widths of the words on the two channels.
    localparam int CODE_W  = 8;
    localparam int COLOR_W = 32;
    localparam int FONT_W  = 8;
    localparam int PIXX_W  = 10;
    localparam int PIXY_W  = 9;

    // Cursor widths: wide enough to hold one cell past the last column or row.
    localparam int CCOL_W = $clog2(SCREEN_WIDTH + 1);
    localparam int CROW_W = $clog2(SCREEN_HEIGHT + 1);

    // First pixel of the last cell of a row, and of the bottom text row.
    localparam int LAST_COL = ((SCREEN_WIDTH / GLYPH_WIDTH) - 1) * GLYPH_WIDTH;
    localparam int LAST_ROW = ((SCREEN_HEIGHT / GLYPH_HEIGHT) - 1) * GLYPH_HEIGHT;

    // Counters over the pixels of one glyph.
    localparam int GCOL_W = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
    localparam int GROW_W = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

    // Operation codes.
    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Character codes with special handling.
    localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CODE_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CODE_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CODE_W-1:0] CH_SPACE     = 8'd32;

    typedef struct packed {
        logic                opcode;
        logic [CODE_W-1:0]   char_code;
        logic [COLOR_W-1:0]  draw_color;
        logic [STORE_AW-1:0] font_address;
        logic [FONT_W-1:0]   font_data;
    } req_word_t;

    typedef struct packed {
        logic [PIXX_W-1:0]  pixel_x;
        logic [PIXY_W-1:0]  pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_pixel;
    } pix_word_t;

endpackage

// File: rtl/core/text_console_glyph_renderer_top.sv
// Top level of the text console glyph renderer: cursor, font store and pixel sequencer.

// The renderer takes one request word at a time. A font load word writes one glyph
// byte into the font RAM. Carriage return and newline only move the cursor. A
// printable character, or a backspace (which blanks the cell it steps back onto with
// the space glyph), produces GLYPH_WIDTH * GLYPH_HEIGHT pixel words, 64 at the 8 by 8
// default, and holds the request channel stalled through ST_PRIME and ST_EMIT. The
// request is accepted in ST_IDLE, which starts the first font read; ST_PRIME loads the
// first glyph row; then ST_EMIT gives one pixel per cycle when the pixel channel never
// stalls. The rate is set by the glyph row shift register, which moves one bit out per
// cycle; the next row is fetched from the font RAM (registered read) while the current
// one is shifting, so rows follow without a gap. The pixel word sits in an output
// register, so the next request can be taken while the last pixel of a character
// still waits on pix_stall. The font RAM has no clearing pass: glyphs must be loaded
// before they are drawn.
module text_console_glyph_renderer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  tcgr_pkg::req_word_t req_word,
    output logic               pix_valid,
    input  logic               pix_stall,
    output tcgr_pkg::pix_word_t pix_word
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    // Cursor position in pixels, top left corner of the current cell.
    logic [tcgr_pkg::CCOL_W-1:0] cur_col_reg, cur_col_next;
    logic [tcgr_pkg::CROW_W-1:0] cur_row_reg, cur_row_next;

    // Cell being rendered.
    logic [tcgr_pkg::CCOL_W-1:0]  base_x_reg, base_x_next;
    logic [tcgr_pkg::CROW_W-1:0]  base_y_reg, base_y_next;
    logic [tcgr_pkg::COLOR_W-1:0] color_reg, color_next;
    logic [tcgr_pkg::STORE_AW-1:0] fetch_addr_reg, fetch_addr_next;

    // Glyph row shift register, most significant bit leaves first.
    logic [tcgr_pkg::GLYPH_WIDTH-1:0] bits_reg, bits_next;
    logic [tcgr_pkg::GCOL_W-1:0]      gcol_reg, gcol_next;
    logic [tcgr_pkg::GROW_W-1:0]      grow_reg, grow_next;

    // Output register.
    logic                 pix_valid_reg, pix_valid_next;
    tcgr_pkg::pix_word_t  pix_word_reg, pix_word_next;

    // Font RAM ports.
    logic                          ram_wr_en;
    logic                          ram_rd_en;
    logic [tcgr_pkg::STORE_AW-1:0] ram_rd_addr;
    logic [tcgr_pkg::FONT_W-1:0]   ram_rd_data;

    logic accept;
    logic advance;
    logic row_end;
    logic cell_end;

    // Cursor arithmetic for a draw request.
    logic [tcgr_pkg::CCOL_W-1:0] col_plus;
    logic [tcgr_pkg::CROW_W-1:0] row_plus;
    logic [tcgr_pkg::CCOL_W-1:0] bs_col;
    logic [tcgr_pkg::CROW_W-1:0] bs_row;
    logic [tcgr_pkg::CODE_W-1:0] render_code;
    logic [tcgr_pkg::STORE_AW-1:0] glyph_base;

    logic [tcgr_pkg::CCOL_W:0] pix_x_sum;
    logic [tcgr_pkg::CROW_W:0] pix_y_sum;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign advance   = (state_reg == ST_EMIT) && (!pix_valid_reg || !pix_stall);
    assign row_end   = (gcol_reg == tcgr_pkg::GCOL_W'(tcgr_pkg::GLYPH_WIDTH - 1));
    assign cell_end  = row_end && (grow_reg == tcgr_pkg::GROW_W'(tcgr_pkg::GLYPH_HEIGHT - 1));

    assign col_plus = cur_col_reg + tcgr_pkg::CCOL_W'(tcgr_pkg::GLYPH_WIDTH);
    assign row_plus = cur_row_reg + tcgr_pkg::CROW_W'(tcgr_pkg::GLYPH_HEIGHT);

    // Backspace target cell: step back one cell, wrapping to the end of the row
    // above, and from home to the last cell of the bottom row.
    always_comb
    begin
        bs_col = cur_col_reg;
        bs_row = cur_row_reg;
        if (cur_col_reg == '0)
        begin
            bs_col = tcgr_pkg::CCOL_W'(tcgr_pkg::LAST_COL);
            if (cur_row_reg < tcgr_pkg::CROW_W'(tcgr_pkg::GLYPH_HEIGHT))
            begin
                bs_row = tcgr_pkg::CROW_W'(tcgr_pkg::LAST_ROW);
            end
            else
            begin
                bs_row = cur_row_reg - tcgr_pkg::CROW_W'(tcgr_pkg::GLYPH_HEIGHT);
            end
        end
        else if (cur_col_reg < tcgr_pkg::CCOL_W'(tcgr_pkg::GLYPH_WIDTH))
        begin
            bs_col = '0;
        end
        else
        begin
            bs_col = cur_col_reg - tcgr_pkg::CCOL_W'(tcgr_pkg::GLYPH_WIDTH);
        end
    end

    assign render_code = (req_word.char_code == tcgr_pkg::CH_BACKSPACE)
                         ? tcgr_pkg::CH_SPACE : req_word.char_code;
    // Glyph address wraps modulo the store depth.
    assign glyph_base  = tcgr_pkg::STORE_AW'(render_code * tcgr_pkg::GLYPH_HEIGHT);

    assign pix_x_sum = {1'b0, base_x_reg} + (tcgr_pkg::CCOL_W + 1)'(gcol_reg);
    assign pix_y_sum = {1'b0, base_y_reg} + (tcgr_pkg::CROW_W + 1)'(grow_reg);

    assign ram_wr_en = accept && (req_word.opcode == tcgr_pkg::OP_LOAD);

    always_comb
    begin
        state_next      = state_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        base_x_next     = base_x_reg;
        base_y_next     = base_y_reg;
        color_next      = color_reg;
        fetch_addr_next = fetch_addr_reg;
        bits_next       = bits_reg;
        gcol_next       = gcol_reg;
        grow_next       = grow_reg;
        pix_valid_next  = pix_valid_reg;
        pix_word_next   = pix_word_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = fetch_addr_reg;

        // The output word leaves when it is taken; a new one may replace it below.
        if (pix_valid_reg && !pix_stall)
        begin
            pix_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_word.opcode == tcgr_pkg::OP_DRAW))
                begin
                    if (req_word.char_code == tcgr_pkg::CH_RETURN)
                    begin
                        cur_col_next = '0;
                    end
                    else if (req_word.char_code == tcgr_pkg::CH_NEWLINE)
                    begin
                        cur_col_next = '0;
                        cur_row_next = (row_plus > tcgr_pkg::CROW_W'(tcgr_pkg::LAST_ROW))
                                       ? '0 : row_plus;
                    end
                    else
                    begin
                        // Start rendering: first glyph row read goes out now.
                        ram_rd_en       = 1'b1;
                        ram_rd_addr     = glyph_base;
                        fetch_addr_next = glyph_base + tcgr_pkg::STORE_AW'(1);
                        color_next      = req_word.draw_color;
                        state_next      = ST_PRIME;
                        if (req_word.char_code == tcgr_pkg::CH_BACKSPACE)
                        begin
                            base_x_next  = bs_col;
                            base_y_next  = bs_row;
                            cur_col_next = bs_col;
                            cur_row_next = bs_row;
                        end
                        else
                        begin
                            base_x_next = cur_col_reg;
                            base_y_next = cur_row_reg;
                            if (col_plus > tcgr_pkg::CCOL_W'(tcgr_pkg::LAST_COL))
                            begin
                                cur_col_next = '0;
                                cur_row_next = (row_plus > tcgr_pkg::CROW_W'(tcgr_pkg::LAST_ROW))
                                               ? '0 : row_plus;
                            end
                            else
                            begin
                                cur_col_next = col_plus;
                            end
                        end
                    end
                end
            end

            ST_PRIME:
            begin
                // Row 0 is in the RAM output; prefetch row 1.
                bits_next       = ram_rd_data[tcgr_pkg::GLYPH_WIDTH-1:0];
                gcol_next       = '0;
                grow_next       = '0;
                ram_rd_en       = 1'b1;
                ram_rd_addr     = fetch_addr_reg;
                fetch_addr_next = fetch_addr_reg + tcgr_pkg::STORE_AW'(1);
                state_next      = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (advance)
                begin
                    pix_valid_next             = 1'b1;
                    pix_word_next.pixel_x      = tcgr_pkg::PIXX_W'(pix_x_sum);
                    pix_word_next.pixel_y      = tcgr_pkg::PIXY_W'(pix_y_sum);
                    pix_word_next.pixel_color  = bits_reg[tcgr_pkg::GLYPH_WIDTH-1]
                                                 ? color_reg : '0;
                    pix_word_next.last_pixel   = cell_end;
                    bits_next = bits_reg << 1;
                    gcol_next = gcol_reg + tcgr_pkg::GCOL_W'(1);
                    if (cell_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (row_end)
                    begin
                        bits_next       = ram_rd_data[tcgr_pkg::GLYPH_WIDTH-1:0];
                        gcol_next       = '0;
                        grow_next       = grow_reg + tcgr_pkg::GROW_W'(1);
                        ram_rd_en       = 1'b1;
                        ram_rd_addr     = fetch_addr_reg;
                        fetch_addr_next = fetch_addr_reg + tcgr_pkg::STORE_AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            base_x_reg     <= '0;
            base_y_reg     <= '0;
            color_reg      <= '0;
            fetch_addr_reg <= '0;
            bits_reg       <= '0;
            gcol_reg       <= '0;
            grow_reg       <= '0;
            pix_valid_reg  <= 1'b0;
            pix_word_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            base_x_reg     <= base_x_next;
            base_y_reg     <= base_y_next;
            color_reg      <= color_next;
            fetch_addr_reg <= fetch_addr_next;
            bits_reg       <= bits_next;
            gcol_reg       <= gcol_next;
            grow_reg       <= grow_next;
            pix_valid_reg  <= pix_valid_next;
            pix_word_reg   <= pix_word_next;
        end
    end

    // Font store: glyph bytes written by load words, read one row ahead of the shifter.
    tcgr_ram #(
        .WIDTH (tcgr_pkg::FONT_W),
        .DEPTH (tcgr_pkg::STORE_DEPTH)
    ) u_font_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (req_word.font_address),
        .wr_data (req_word.font_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign pix_valid = pix_valid_reg;
    assign pix_word  = pix_word_reg;

endmodule

// File: rtl/core/tcgr_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/tcgr_checker.sv
// Port-level assertions for the text console glyph renderer, bound to its top level.
module tcgr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_stall,
    input logic                pix_valid,
    input logic                pix_stall,
    input tcgr_pkg::pix_word_t pix_word
);

    // While a character is only part way out, no new request is taken.
    a_busy_mid_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_word.last_pixel) |-> req_stall)
        else $error("request channel open while a character is part way out");

    // Pixels of one character follow each other with no gap.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_stall && !pix_word.last_pixel) |=> pix_valid)
        else $error("gap inside a character's pixel words");

    // A stalled pixel word stays put.
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_stall) |=> (pix_valid && $stable(pix_word)))
        else $error("stalled pixel word changed or dropped");

endmodule

bind text_console_glyph_renderer_top tcgr_checker u_tcgr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_word  (pix_word)
);
